// File: rtl/epa_pkg.sv
package epa_pkg;

  localparam int unsigned RAW_W  = 16;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned MULT_W = 16;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Unwrapped difference fits in 18 bits, product in 18 + 16
  localparam int unsigned DIFF_W = RAW_W + 2;
  localparam int unsigned PROD_W = DIFF_W + MULT_W;
  localparam int unsigned SUM_W  = PROD_W + 2;

  localparam logic [15:0]       PERIOD_RST = 16'hFFFF;
  localparam logic signed [15:0] MULT_RST  = 16'sd1;
  localparam logic signed [31:0] LOWER_RST = -32'sd2000000000;
  localparam logic signed [31:0] UPPER_RST = 32'sd2000000000;

  typedef enum logic [2:0] {
    REG_PERIOD = 3'd0,
    REG_MULT   = 3'd1,
    REG_LOWER  = 3'd2,
    REG_UPPER  = 3'd3,
    REG_LOOP   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_SET    = 2'd1,
    CMD_RESYNC = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [15:0]        period;
    logic signed [15:0] mult;
    logic signed [31:0] lo_bound;
    logic signed [31:0] hi_bound;
    logic               loop_mode;
  } cfg_t;

endpackage

// File: rtl/encoder_position_accumulator_core.sv
// Encoder position accumulator.
// Input channel (in_valid/in_ready): one beat per command. SAMPLE carries a
// raw counter reading that is unwrapped against the previous reading, scaled
// by the step multiplier and added to the position, then clamped or looped
// at the limits. SET loads the position directly; RESYNC only moves the raw
// baseline. Every input beat gives exactly one output beat (out_position,
// out_changed), in order.
// On the way to out_valid a beat is registered in each stage: the first does
// the unwrap and the 18x16 multiply, the second does the wide add and the
// limit check against the running position. One beat per cycle sustained
// while out_ready stays high; on a stall one more beat still enters the first
// stage, and in_ready drops only when both stages hold data. Configuration is
// an APB register file (pready always high), written by the user only while
// the block is idle; the block does not enforce this. Synchronous reset loads
// the register defaults and clears position, baseline and all valid flags.
module encoder_position_accumulator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_command,
  input  logic signed [15:0]          in_raw_count,
  input  logic signed [31:0]          in_new_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_position,
  output logic                        out_changed,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [epa_pkg::APB_AW-1:0]  paddr,
  input  logic [epa_pkg::APB_DW-1:0]  pwdata,
  output logic [epa_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  epa_pkg::cfg_t cfg;

  epa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------- stage 1: unwrap and scale ----------------
  logic signed [epa_pkg::RAW_W-1:0]  last_raw_r;
  logic                              s1_valid_r;
  epa_pkg::cmd_t                     s1_cmd_r;
  logic                              s1_acc_r;
  logic signed [epa_pkg::PROD_W-1:0] s1_prod_r;
  logic signed [31:0]                s1_nv_r;

  epa_pkg::cmd_t                     cmd_in;
  logic signed [epa_pkg::DIFF_W-1:0] diff;
  logic signed [epa_pkg::DIFF_W-1:0] half_s;
  logic signed [epa_pkg::DIFF_W-1:0] period_s;
  logic signed [epa_pkg::DIFF_W-1:0] unwrap;
  logic signed [epa_pkg::PROD_W-1:0] prod;
  logic                              acc_en;
  logic                              in_fire;
  logic                              s1_adv;

  assign cmd_in   = epa_pkg::cmd_t'(in_command);
  assign diff     = {{2{in_raw_count[15]}}, in_raw_count} - {{2{last_raw_r[15]}}, last_raw_r};
  assign half_s   = $signed({3'b000, cfg.period[15:1]});
  assign period_s = $signed({2'b00, cfg.period});

  always_comb begin
    if (diff > half_s) begin
      unwrap = diff - period_s;
    end else if (diff < -half_s) begin
      unwrap = diff + period_s;
    end else begin
      unwrap = diff;
    end
  end

  assign prod   = unwrap * cfg.mult;
  assign acc_en = (in_command == epa_pkg::CMD_SAMPLE) && (in_raw_count != last_raw_r);

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      last_raw_r <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        if (in_command == epa_pkg::CMD_SAMPLE || in_command == epa_pkg::CMD_RESYNC) begin
          last_raw_r <= in_raw_count;
        end
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= cmd_in;
      s1_acc_r  <= acc_en;
      s1_prod_r <= prod;
      s1_nv_r   <= in_new_value;
    end
  end

  // ---------------- stage 2: accumulate and limit ----------------
  logic signed [31:0]               position_r;
  logic signed [31:0]               last_reported_r;
  logic                             out_valid_r;
  logic signed [31:0]               out_position_r;
  logic                             out_changed_r;

  logic signed [epa_pkg::SUM_W-1:0] sum;
  logic signed [epa_pkg::SUM_W-1:0] lo_w;
  logic signed [epa_pkg::SUM_W-1:0] hi_w;
  logic signed [31:0]               limited;
  logic signed [31:0]               pos_nxt;
  logic                             chg_nxt;
  logic                             s2_fire;

  assign s2_fire = s1_valid_r && s1_adv;
  assign sum  = {{(epa_pkg::SUM_W-32){position_r[31]}}, position_r}
              + {{(epa_pkg::SUM_W-epa_pkg::PROD_W){s1_prod_r[epa_pkg::PROD_W-1]}}, s1_prod_r};
  assign lo_w = {{(epa_pkg::SUM_W-32){cfg.lo_bound[31]}}, cfg.lo_bound};
  assign hi_w = {{(epa_pkg::SUM_W-32){cfg.hi_bound[31]}}, cfg.hi_bound};

  always_comb begin
    if (sum > hi_w) begin
      limited = cfg.loop_mode ? cfg.lo_bound : cfg.hi_bound;
    end else if (sum < lo_w) begin
      limited = cfg.loop_mode ? cfg.hi_bound : cfg.lo_bound;
    end else begin
      limited = sum[31:0];
    end
  end

  always_comb begin
    pos_nxt = position_r;
    unique case (s1_cmd_r)
      epa_pkg::CMD_SAMPLE: if (s1_acc_r) pos_nxt = limited;
      epa_pkg::CMD_SET:    pos_nxt = s1_nv_r;
      default: ;
    endcase
  end

  // a SET also loads the report, so it never flags a change
  assign chg_nxt = (s1_cmd_r != epa_pkg::CMD_SET) && (pos_nxt != last_reported_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r      <= '0;
      last_reported_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (s2_fire) begin
        position_r      <= pos_nxt;
        last_reported_r <= pos_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_position_r <= pos_nxt;
      out_changed_r  <= chg_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_changed  = out_changed_r;

  // ---------------- checks ----------------
  a_report_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    position_r == last_reported_r)
    else $error("report register diverged from position");

  a_set_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && s1_cmd_r == epa_pkg::CMD_SET |=> !out_changed && out_position == $past(s1_nv_r))
    else $error("set position result wrong");

  a_acc_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && s1_cmd_r == epa_pkg::CMD_SAMPLE && s1_acc_r
    |=> position_r >= $past(cfg.lo_bound) && position_r <= $past(cfg.hi_bound))
    else $error("accumulated position outside limits");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_fire |=> $stable(position_r))
    else $error("position moved without a beat");

endmodule

// File: rtl/epa_cfg.sv
module epa_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [epa_pkg::APB_AW-1:0]      paddr,
  input  logic [epa_pkg::APB_DW-1:0]      pwdata,
  output logic [epa_pkg::APB_DW-1:0]      prdata,
  output logic                            pready,
  output epa_pkg::cfg_t                   cfg
);

  logic [15:0]        period_r;
  logic signed [15:0] mult_r;
  logic signed [31:0] lower_r;
  logic signed [31:0] upper_r;
  logic               loop_r;
  logic               wr_en;
  logic [2:0]         idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= epa_pkg::PERIOD_RST;
      mult_r   <= epa_pkg::MULT_RST;
      lower_r  <= epa_pkg::LOWER_RST;
      upper_r  <= epa_pkg::UPPER_RST;
      loop_r   <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        epa_pkg::REG_PERIOD: period_r <= pwdata[15:0];
        epa_pkg::REG_MULT:   mult_r   <= $signed(pwdata[15:0]);
        epa_pkg::REG_LOWER:  lower_r  <= $signed(pwdata);
        epa_pkg::REG_UPPER:  upper_r  <= $signed(pwdata);
        epa_pkg::REG_LOOP:   loop_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      epa_pkg::REG_PERIOD: prdata = {16'd0, period_r};
      epa_pkg::REG_MULT:   prdata = {16'd0, mult_r};
      epa_pkg::REG_LOWER:  prdata = lower_r;
      epa_pkg::REG_UPPER:  prdata = upper_r;
      epa_pkg::REG_LOOP:   prdata = {31'd0, loop_r};
      default:             prdata = '0;
    endcase
  end

  // limits are used in order, whichever register holds the smaller one
  always_comb begin
    cfg.period    = period_r;
    cfg.mult      = mult_r;
    cfg.loop_mode = loop_r;
    if (lower_r < upper_r) begin
      cfg.lo_bound = lower_r;
      cfg.hi_bound = upper_r;
    end else begin
      cfg.lo_bound = upper_r;
      cfg.hi_bound = lower_r;
    end
  end

endmodule

// File: dv/tb_encoder_position_accumulator_core.sv
module tb_encoder_position_accumulator_core;
  import epa_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;  // undefined command, only refreshes the report
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned BEATS_PER_PHASE = 200;
  localparam int unsigned PRINT_CAP = 100;

  typedef struct packed {
    logic signed [31:0] pos;
    logic               chg;
  } report_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] raw;
    logic signed [31:0] nv;
    logic               typed_in;  // expected value given in the row
    logic signed [31:0] pos;
    logic               chg;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_command = CMD_SAMPLE;
  logic signed [15:0]         in_raw_count = '0;
  logic signed [31:0]         in_new_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b1;
  logic signed [31:0]         out_position;
  logic                       out_changed;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [APB_AW-1:0]          paddr = '0;
  logic [APB_DW-1:0]          pwdata = '0;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;

  // predictor state and its copy of the registers
  cfg_t                       cfg;
  logic signed [15:0]         trk_raw = '0;
  logic signed [31:0]         trk_pos = '0;
  logic signed [31:0]         trk_rep = '0;

  report_t                    expected_reports[$];
  report_t                    want;
  dir_row_t                   dir_rows [21];

  int unsigned                tx_gap = 1;
  int unsigned                rx_hold = 0;
  int unsigned                rx_draw;
  bit                         no_idle = 1'b0;
  int unsigned                cycle_count = 0;
  int unsigned                mismatches = 0;
  int unsigned                beats_in = 0;
  int unsigned                results_seen = 0;

  encoder_position_accumulator_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_raw_count (in_raw_count),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_position (out_position),
    .out_changed  (out_changed),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
               expected_reports.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input longint want_v, input longint got_v);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH %s: expected %0d, got %0d (result %0d)", what, want_v, got_v,
               results_seen);
    mismatches++;
  endtask

  task automatic track_position(input logic [1:0] cmd, input logic signed [15:0] raw,
                                input logic signed [31:0] nv,
                                output logic signed [31:0] pos, output logic chg);
    longint diff;
    longint total;
    longint half;
    longint lo_v;
    longint hi_v;
    case (cmd)
      CMD_SAMPLE: begin
        if (raw != trk_raw) begin
          diff = longint'(raw) - longint'(trk_raw);
          trk_raw = raw;
          half = longint'(cfg.period) / 2;
          if (diff > half) diff -= longint'(cfg.period);
          else if (diff < -half) diff += longint'(cfg.period);
          total = longint'(trk_pos) + diff * longint'(cfg.mult);
          // limits are taken in order, whichever register holds the smaller
          lo_v = longint'(cfg.lo_bound);
          hi_v = longint'(cfg.hi_bound);
          if (hi_v < lo_v) begin
            lo_v = longint'(cfg.hi_bound);
            hi_v = longint'(cfg.lo_bound);
          end
          if (cfg.loop_mode) begin
            if (total > hi_v) total = lo_v;
            if (total < lo_v) total = hi_v;
          end else begin
            if (total > hi_v) total = hi_v;
            if (total < lo_v) total = lo_v;
          end
          trk_pos = total[31:0];
        end
      end
      CMD_SET: begin
        trk_pos = nv;
        trk_rep = nv;
      end
      CMD_RESYNC: trk_raw = raw;
      default: ;
    endcase
    chg = (trk_pos != trk_rep);
    trk_rep = trk_pos;
    pos = trk_pos;
  endtask

  task automatic send_beat(input logic [1:0] cmd, input logic signed [15:0] raw,
                           input logic signed [31:0] nv, input logic typed_in,
                           input logic signed [31:0] typed_pos, input logic typed_chg);
    report_t rpt;
    if (tx_gap != 0) repeat (tx_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_raw_count <= raw;
    in_new_value <= nv;
    do @(posedge clk); while (!in_ready);
    track_position(cmd, raw, nv, rpt.pos, rpt.chg);
    if (typed_in) begin
      rpt.pos = typed_pos;
      rpt.chg = typed_chg;
    end
    expected_reports.push_back(rpt);
    beats_in++;
    // valid stays up when the next beat follows at once
    tx_gap = no_idle ? 0 : $urandom_range(0, 3);
    if (tx_gap != 0) in_valid <= 1'b0;
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    if (tx_gap == 0) in_valid <= 1'b0;
    tx_gap = 1;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val, input bit last);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (last) begin
      psel <= 1'b0;
      penable <= 1'b0;
    end
    case (idx)
      REG_PERIOD: cfg.period = val[15:0];
      REG_MULT:   cfg.mult = val[15:0];
      REG_LOWER:  cfg.lo_bound = val;
      REG_UPPER:  cfg.hi_bound = val;
      REG_LOOP:   cfg.loop_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] period, input logic signed [15:0] mult,
                              input logic signed [31:0] lo, input logic signed [31:0] hi,
                              input logic loop_on);
    write_reg(REG_PERIOD, {16'h0, period}, 1'b0);
    write_reg(REG_MULT, {{16{mult[15]}}, mult}, 1'b0);
    write_reg(REG_LOWER, lo, 1'b0);
    write_reg(REG_UPPER, hi, 1'b0);
    write_reg(REG_LOOP, {31'h0, loop_on}, 1'b1);
  endtask

  // receiver: random stall after each accepted result
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) out_ready <= 1'b1;
    end else if (out_valid && out_ready && !no_idle) begin
      rx_draw = $urandom_range(0, 3);
      if (rx_draw != 0) begin
        out_ready <= 1'b0;
        rx_hold <= rx_draw;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        flag_mismatch("unexpected result beat, position", 0, out_position);
      end else begin
        want = expected_reports.pop_front();
        if (out_position !== want.pos) flag_mismatch("position", want.pos, out_position);
        if (out_changed !== want.chg) flag_mismatch("changed", want.chg, out_changed);
        results_seen++;
      end
    end
  end

  initial begin
    int unsigned kind;
    int half;
    logic [1:0] cmd;
    logic signed [15:0] raw;
    logic signed [31:0] nv;

    cfg = '{PERIOD_RST, MULT_RST, LOWER_RST, UPPER_RST, 1'b0};
    dir_rows = '{
      '{CMD_SAMPLE, 16'sd0,      32'sd0,           1'b1, 32'sd0,           1'b0},
      '{CMD_SET,    16'sd0,      32'sh7FFF_FFFF,   1'b1, 32'sh7FFF_FFFF,   1'b0},
      '{CMD_NOP,    16'sd5,      32'sd5,           1'b1, 32'sh7FFF_FFFF,   1'b0},
      '{CMD_SET,    16'sd0,      32'sh8000_0000,   1'b1, 32'sh8000_0000,   1'b0},
      // one count up from the minimum still lies below the lower limit
      '{CMD_SAMPLE, 16'sd1,      32'sd0,           1'b1, -32'sd2000000000, 1'b1},
      '{CMD_SET,    16'sd0,      32'sd1999999990,  1'b1, 32'sd1999999990,  1'b0},
      '{CMD_SAMPLE, 16'sd101,    32'sd0,           1'b1, 32'sd2000000000,  1'b1},
      '{CMD_SAMPLE, 16'sd101,    32'sd0,           1'b1, 32'sd2000000000,  1'b0},
      '{CMD_RESYNC, -16'sd32768, 32'sd123,         1'b1, 32'sd2000000000,  1'b0},
      // full period forward unwraps to no motion
      '{CMD_SAMPLE, 16'sd32767,  32'sd0,           1'b1, 32'sd2000000000,  1'b0},
      '{CMD_SET,    16'sd0,      32'sd0,           1'b1, 32'sd0,           1'b0},
      '{CMD_SAMPLE, -16'sd32768, 32'sd0,           1'b0, 32'sd0,           1'b0},
      '{CMD_SAMPLE, 16'sd0,      32'sd0,           1'b0, 32'sd0,           1'b0},
      '{CMD_SAMPLE, -16'sd32767, 32'sd0,           1'b0, 32'sd0,           1'b0},
      '{CMD_SAMPLE, 16'sd0,      32'sd0,           1'b0, 32'sd0,           1'b0},
      '{CMD_NOP,    -16'sd1,     -32'sd1,          1'b0, 32'sd0,           1'b0},
      '{CMD_RESYNC, 16'sd32767,  32'sd0,           1'b0, 32'sd0,           1'b0},
      '{CMD_SAMPLE, -16'sd32768, 32'sd0,           1'b0, 32'sd0,           1'b0},
      '{CMD_SET,    16'sd0,      -32'sd1,          1'b1, -32'sd1,          1'b0},
      '{CMD_SAMPLE, 16'sh5555,   32'sh5555_5555,   1'b0, 32'sd0,           1'b0},
      '{CMD_SAMPLE, 16'shAAAA,   32'shAAAA_AAAA,   1'b0, 32'sd0,           1'b0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].cmd, dir_rows[i].raw, dir_rows[i].nv, dir_rows[i].typed_in,
                dir_rows[i].pos, dir_rows[i].chg);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: program_regs(16'hFFFF, 16'sd1, LOWER_RST, UPPER_RST, 1'b0);
        1: program_regs(16'hFFFF, 16'sh7FFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        2: program_regs(16'd1000, 16'sh8000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
        3: program_regs(16'd1, 16'sd7, -32'sd5000, 32'sd5000, 1'b1);
        4: program_regs(16'd0, -16'sd1, 32'sd300, -32'sd300, 1'b0);
        5: program_regs(16'd2, 16'sd0, 32'sd0, 32'sd0, 1'b1);
        6: program_regs(16'hFFFF, 16'sh7FFF, -32'sd100000, 32'sd100000, 1'b1);
        default: begin
          if ($urandom_range(0, 1))
            program_regs(16'($urandom_range(0, 65535)), 16'($urandom),
                         int'($urandom_range(0, 200000)) - 100000,
                         int'($urandom_range(0, 200000)) - 100000,
                         1'($urandom_range(0, 1)));
          else
            program_regs(16'($urandom_range(0, 65535)), 16'($urandom), $urandom, $urandom,
                         1'($urandom_range(0, 1)));
        end
      endcase

      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        no_idle = (phase % 3 == 1) && (n < BEATS_PER_PHASE / 2);
        if ($urandom_range(0, 149) == 0) settle();
        kind = $urandom_range(0, 99);
        cmd = CMD_SAMPLE;
        raw = 16'($urandom);
        nv = $urandom;
        half = int'(cfg.period) / 2;
        if (kind < 55) begin
          raw = 16'(int'(trk_raw) + int'($urandom_range(0, 600)) - 300);
        end else if (kind < 65) begin
          // straddle the unwrap threshold
          case ($urandom_range(0, 3))
            0: raw = 16'(int'(trk_raw) + half);
            1: raw = 16'(int'(trk_raw) + half + 1);
            2: raw = 16'(int'(trk_raw) - half);
            default: raw = 16'(int'(trk_raw) - half - 1);
          endcase
        end else if (kind < 72) begin
          // fully random reading already drawn
        end else if (kind < 76) begin
          raw = trk_raw;
        end else if (kind < 86) begin
          cmd = CMD_SET;
          if ($urandom_range(0, 1))
            nv = ($urandom_range(0, 1) ? cfg.lo_bound : cfg.hi_bound) +
                 int'($urandom_range(0, 40)) - 20;
        end else if (kind < 95) begin
          cmd = CMD_RESYNC;
        end else begin
          cmd = CMD_NOP;
        end
        send_beat(cmd, raw, nv, 1'b0, '0, 1'b0);
      end
    end

    no_idle = 1'b0;
    settle();
    repeat (8) @(posedge clk);

    $display("Sent %0d beats and checked %0d results across %0d register settings,",
             beats_in, results_seen, PHASES + 1);
    $display("covering clamp and loop, swapped limits, unwrap edges and random stalls.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
